// File: rtl/core/wrts_pkg.sv
// Shared types, constants and the control store for the relay timer scheduler.
package wrts_pkg;

   // Item operation codes.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FORCE = 2'd2;

   // A repeat mask of zero marks a one-shot task.
   localparam logic [6:0] ONE_SHOT_MASK = 7'h00;

   // Datapath operation selected by each control word.
   typedef enum logic [2:0] {
      DP_NOP,
      DP_LATCH,
      DP_CLEAR,
      DP_PRIME,
      DP_EVAL,
      DP_WRITE,
      DP_FORCE,
      DP_RESPOND
   } dp_op_type;

   // Jump condition selected by each control word.
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_ACCEPT,
      C_IS_WRITE,
      C_IS_FORCE,
      C_NOT_SCAN,
      C_MORE,
      C_OUT_BUSY
   } cond_type;

   typedef logic [3:0] upc_type;

   // Program step addresses.
   localparam upc_type STEP_WAIT       = 4'd0;
   localparam upc_type STEP_DECODE     = 4'd1;
   localparam upc_type STEP_FORCE_TEST = 4'd2;
   localparam upc_type STEP_SCAN_TEST  = 4'd3;
   localparam upc_type STEP_PRIME      = 4'd4;
   localparam upc_type STEP_EVAL       = 4'd5;
   localparam upc_type STEP_RESP       = 4'd6;
   localparam upc_type STEP_RETURN     = 4'd7;
   localparam upc_type STEP_WRITE      = 4'd8;
   localparam upc_type STEP_FORCE      = 4'd9;

   typedef struct packed {
      logic      in_ready;
      dp_op_type op;
      cond_type  cond;
      upc_type   target;
   } ucode_word_type;

   typedef struct packed {
      logic accepted;
      logic is_write;
      logic is_force;
      logic not_scan;
      logic more;
      logic out_busy;
   } dp_status_type;

   // The control program. A true condition jumps to the target; otherwise the
   // step counter advances by one.
   function automatic ucode_word_type ucode_rom(input upc_type step);
      ucode_word_type w;
      case (step)
         STEP_WAIT: begin
            w = '{in_ready: 1'b1, op: DP_LATCH, cond: C_NO_ACCEPT, target: STEP_WAIT};
         end
         STEP_DECODE: begin
            w = '{in_ready: 1'b0, op: DP_CLEAR, cond: C_IS_WRITE, target: STEP_WRITE};
         end
         STEP_FORCE_TEST: begin
            w = '{in_ready: 1'b0, op: DP_NOP, cond: C_IS_FORCE, target: STEP_FORCE};
         end
         STEP_SCAN_TEST: begin
            w = '{in_ready: 1'b0, op: DP_NOP, cond: C_NOT_SCAN, target: STEP_RESP};
         end
         STEP_PRIME: begin
            w = '{in_ready: 1'b0, op: DP_PRIME, cond: C_NEVER, target: STEP_WAIT};
         end
         STEP_EVAL: begin
            w = '{in_ready: 1'b0, op: DP_EVAL, cond: C_MORE, target: STEP_EVAL};
         end
         STEP_RESP: begin
            w = '{in_ready: 1'b0, op: DP_RESPOND, cond: C_OUT_BUSY, target: STEP_RESP};
         end
         STEP_RETURN: begin
            w = '{in_ready: 1'b0, op: DP_NOP, cond: C_ALWAYS, target: STEP_WAIT};
         end
         STEP_WRITE: begin
            w = '{in_ready: 1'b0, op: DP_WRITE, cond: C_ALWAYS, target: STEP_RESP};
         end
         STEP_FORCE: begin
            w = '{in_ready: 1'b0, op: DP_FORCE, cond: C_ALWAYS, target: STEP_RESP};
         end
         default: begin
            w = '{in_ready: 1'b0, op: DP_NOP, cond: C_ALWAYS, target: STEP_WAIT};
         end
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/wrts_channels.sv
// Request and response channel interfaces of the relay timer scheduler.
interface wrts_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [2:0] plug_index;
   logic [2:0] task_index;
   logic [4:0] hour;
   logic [5:0] minute;
   logic [5:0] second;
   logic [2:0] weekday;
   logic [6:0] repeat_mask;
   logic       action;
   logic       enable;

   modport source (
      output valid, operation, plug_index, task_index, hour, minute, second,
             weekday, repeat_mask, action, enable,
      input  ready
   );
   modport sink (
      input  valid, operation, plug_index, task_index, hour, minute, second,
             weekday, repeat_mask, action, enable,
      output ready
   );
endinterface

interface wrts_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] relay_states;
   logic [5:0] changed_mask;
   logic       store_dirty;

   modport source (
      output valid, relay_states, changed_mask, store_dirty,
      input  ready
   );
   modport sink (
      input  valid, relay_states, changed_mask, store_dirty,
      output ready
   );
endinterface

// File: rtl/core/weekly_relay_timer_scheduler.sv
// Top level of the weekly relay timer scheduler.
//
// The block keeps NUM_OUTLETS relay outlets with TASKS_PER_OUTLET timed tasks each.
// Items arrive on the req_if channel and each one produces exactly one transfer
// on the rsp_if channel. A write item loads one task slot, a force item sets one
// outlet, and a tick item with second zero scans every task slot in outlet order,
// then task order, switching outlets whose tasks match the time and weekday.
// The response carries the outlet states, the outlets changed during the tick and
// a flag telling software that its saved copy of the state is now stale.
// A small control program sequences the work. A tick scan evaluates one task slot
// per cycle, each read from the task memory one slot ahead of evaluation; its
// response follows the last slot. A write, a force, a tick that does not scan
// and an ignored item skip the scan; a write or a force is applied in its own
// step first. After the response step the program passes a return step before
// the input is ready again.
// One item is processed at a time. The response sits in an output register, so a
// stalled receiver blocks nothing until the next item reaches its response step,
// where the program waits for the register to empty.
// Synchronous reset disables all tasks, turns every outlet off and empties the
// response register; task times, masks and actions stay unknown until written.
module weekly_relay_timer_scheduler #(
   parameter int NUM_OUTLETS      = 6,
   parameter int TASKS_PER_OUTLET = 5
) (
   input  logic       clock,
   input  logic       reset,
   wrts_req_if.sink   req_if,
   wrts_rsp_if.source rsp_if
);
   import wrts_pkg::*;

   ucode_word_type ctrl;
   dp_status_type  status;

   // Sequencer: step counter plus control store.
   wrts_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Datapath: task storage, outlet logic and response register.
   wrts_datapath #(
      .NUM_OUTLETS      (NUM_OUTLETS),
      .TASKS_PER_OUTLET (TASKS_PER_OUTLET)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Once an item is taken, the block works on it and stops accepting.
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while an item was still in work");

   // A new response only appears after the program reached its response step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(ctrl.op == DP_RESPOND))
      else $error("response raised outside the response step");

   // Any changed outlet must also mark the saved state as stale.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.changed_mask != 6'd0) |-> rsp_if.store_dirty)
      else $error("changed mask reported without the dirty flag");

endmodule

// File: rtl/core/wrts_sequencer.sv
// Step counter and control store that sequence the scheduler datapath.
module wrts_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  wrts_pkg::dp_status_type  status,
   output wrts_pkg::ucode_word_type ctrl
);
   import wrts_pkg::*;

   upc_type upc_ff;
   upc_type upc_in;
   logic    take_jump;

   assign ctrl = ucode_rom(upc_ff);

   always_comb begin
      case (ctrl.cond)
         C_NEVER:     take_jump = 1'b0;
         C_ALWAYS:    take_jump = 1'b1;
         C_NO_ACCEPT: take_jump = !status.accepted;
         C_IS_WRITE:  take_jump = status.is_write;
         C_IS_FORCE:  take_jump = status.is_force;
         C_NOT_SCAN:  take_jump = status.not_scan;
         C_MORE:      take_jump = status.more;
         C_OUT_BUSY:  take_jump = status.out_busy;
         default:     take_jump = 1'b1;
      endcase
   end

   always_comb begin
      if (take_jump) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = upc_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// File: rtl/core/wrts_datapath.sv
// Task memory, enable bits, outlet states, scan counters and response register.
module wrts_datapath #(
   parameter int NUM_OUTLETS      = 6,
   parameter int TASKS_PER_OUTLET = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  wrts_pkg::ucode_word_type ctrl,
   output wrts_pkg::dp_status_type  status,
   wrts_req_if.sink                 req_if,
   wrts_rsp_if.source               rsp_if
);
   import wrts_pkg::*;

   localparam int SLOTS = NUM_OUTLETS * TASKS_PER_OUTLET;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int OW    = (NUM_OUTLETS > 1) ? $clog2(NUM_OUTLETS) : 1;
   localparam int TW    = (TASKS_PER_OUTLET > 1) ? $clog2(TASKS_PER_OUTLET) : 1;
   localparam int DEPTH = 2 ** AW;
   localparam logic [AW-1:0] SLOT_LAST = AW'(SLOTS - 1);
   localparam logic [TW-1:0] TASK_LAST = TW'(TASKS_PER_OUTLET - 1);

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [6:0] repeat_mask;
      logic       action;
   } task_entry_type;

   // Weekday 0 is Sunday and maps to mask bit 6; Monday..Saturday map to 0..5.
   function automatic logic [6:0] weekday_bit(input logic [2:0] wd);
      logic [6:0] b;
      if (wd == 3'd0) begin
         b = 7'b100_0000;
      end else if (wd inside {[3'd1:3'd6]}) begin
         b = 7'd1 << (wd - 3'd1);
      end else begin
         b = 7'd0;
      end
      return b;
   endfunction

   // Latched item.
   logic [1:0] item_op_ff;
   logic [2:0] item_plug_ff;
   logic [2:0] item_task_ff;
   logic [4:0] item_hour_ff;
   logic [5:0] item_minute_ff;
   logic [5:0] item_second_ff;
   logic [2:0] item_weekday_ff;
   logic [6:0] item_repeat_ff;
   logic       item_action_ff;
   logic       item_enable_ff;

   task_entry_type task_mem [DEPTH];
   task_entry_type rd_entry_ff;

   logic [SLOTS-1:0]       en_ff, en_in;
   logic [NUM_OUTLETS-1:0] state_ff, state_in;
   logic [NUM_OUTLETS-1:0] changed_ff, changed_in;
   logic                   dirty_ff, dirty_in;
   logic [AW-1:0]          slot_ff, slot_in;
   logic [OW-1:0]          outlet_ff, outlet_in;
   logic [TW-1:0]          tsk_ff, tsk_in;

   logic       rsp_valid_ff;
   logic [5:0] rsp_relay_ff;
   logic [5:0] rsp_changed_ff;
   logic       rsp_dirty_ff;

   logic          accept;
   logic          plug_ok;
   logic          task_ok;
   logic          do_write;
   logic [5:0]    waddr_full;
   logic [AW-1:0] waddr;
   logic [AW-1:0] raddr;
   logic          fire;
   logic          out_busy;
   logic          rsp_load;
   logic [NUM_OUTLETS+5:0] state_pad;
   logic [NUM_OUTLETS+5:0] changed_pad;

   assign req_if.ready = ctrl.in_ready;
   assign accept       = req_if.valid && ctrl.in_ready;

   always_ff @(posedge clock) begin
      if (accept && ctrl.op == DP_LATCH) begin
         item_op_ff      <= req_if.operation;
         item_plug_ff    <= req_if.plug_index;
         item_task_ff    <= req_if.task_index;
         item_hour_ff    <= req_if.hour;
         item_minute_ff  <= req_if.minute;
         item_second_ff  <= req_if.second;
         item_weekday_ff <= req_if.weekday;
         item_repeat_ff  <= req_if.repeat_mask;
         item_action_ff  <= req_if.action;
         item_enable_ff  <= req_if.enable;
      end
   end

   assign plug_ok    = {1'b0, item_plug_ff} < 4'(NUM_OUTLETS);
   assign task_ok    = {1'b0, item_task_ff} < 4'(TASKS_PER_OUTLET);
   assign do_write   = (ctrl.op == DP_WRITE) && plug_ok && task_ok;
   assign waddr_full = ({3'b000, item_plug_ff} * 6'(TASKS_PER_OUTLET))
                       + {3'b000, item_task_ff};
   assign waddr      = waddr_full[AW-1:0];

   // The scan reads one slot ahead of the slot being evaluated.
   assign raddr = (ctrl.op == DP_PRIME) ? '0 : slot_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (do_write) begin
         task_mem[waddr] <= '{hour: item_hour_ff, minute: item_minute_ff,
                              repeat_mask: item_repeat_ff, action: item_action_ff};
      end
      rd_entry_ff <= task_mem[raddr];
   end

   assign fire = en_ff[slot_ff]
                 && rd_entry_ff.hour == item_hour_ff
                 && rd_entry_ff.minute == item_minute_ff
                 && (rd_entry_ff.repeat_mask == ONE_SHOT_MASK
                     || (rd_entry_ff.repeat_mask & weekday_bit(item_weekday_ff)) != 7'd0);

   always_comb begin
      en_in      = en_ff;
      state_in   = state_ff;
      changed_in = changed_ff;
      dirty_in   = dirty_ff;
      slot_in    = slot_ff;
      outlet_in  = outlet_ff;
      tsk_in     = tsk_ff;
      case (ctrl.op)
         DP_CLEAR: begin
            changed_in = '0;
            dirty_in   = 1'b0;
         end
         DP_PRIME: begin
            slot_in   = '0;
            outlet_in = '0;
            tsk_in    = '0;
         end
         DP_EVAL: begin
            if (fire) begin
               if (state_ff[outlet_ff] != rd_entry_ff.action) begin
                  state_in[outlet_ff]   = rd_entry_ff.action;
                  changed_in[outlet_ff] = 1'b1;
                  dirty_in              = 1'b1;
               end
               if (rd_entry_ff.repeat_mask == ONE_SHOT_MASK) begin
                  en_in[slot_ff] = 1'b0;
                  dirty_in       = 1'b1;
               end
            end
            slot_in = slot_ff + AW'(1);
            if (tsk_ff == TASK_LAST) begin
               tsk_in    = '0;
               outlet_in = outlet_ff + OW'(1);
            end else begin
               tsk_in = tsk_ff + TW'(1);
            end
         end
         DP_WRITE: begin
            if (do_write) begin
               en_in[waddr] = item_enable_ff;
            end
         end
         DP_FORCE: begin
            if (plug_ok) begin
               state_in[item_plug_ff[OW-1:0]] = item_action_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff      <= '0;
         state_ff   <= '0;
         changed_ff <= '0;
         dirty_ff   <= 1'b0;
         slot_ff    <= '0;
         outlet_ff  <= '0;
         tsk_ff     <= '0;
      end else begin
         en_ff      <= en_in;
         state_ff   <= state_in;
         changed_ff <= changed_in;
         dirty_ff   <= dirty_in;
         slot_ff    <= slot_in;
         outlet_ff  <= outlet_in;
         tsk_ff     <= tsk_in;
      end
   end

   // Outlets beyond the sixth do not reach the response fields.
   assign state_pad   = {6'b00_0000, state_ff};
   assign changed_pad = {6'b00_0000, changed_ff};

   assign out_busy = rsp_valid_ff && !rsp_if.ready;
   assign rsp_load = (ctrl.op == DP_RESPOND) && !out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_relay_ff   <= state_pad[5:0];
         rsp_changed_ff <= changed_pad[5:0];
         rsp_dirty_ff   <= dirty_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.relay_states = rsp_relay_ff;
   assign rsp_if.changed_mask = rsp_changed_ff;
   assign rsp_if.store_dirty  = rsp_dirty_ff;

   assign status.accepted = accept;
   assign status.is_write = item_op_ff == OP_WRITE;
   assign status.is_force = item_op_ff == OP_FORCE;
   assign status.not_scan = (item_op_ff != OP_TICK) || (item_second_ff != 6'd0);
   assign status.more     = slot_ff != SLOT_LAST;
   assign status.out_busy = out_busy;

endmodule
